@@ rtl/core/csio_pkg.sv @@
// Shared types, sizes and helpers for the cross-staff interval overlap core.
package csio_pkg;

  localparam int STAVES         = 4;
  localparam int NUM_VOICES     = 16;
  localparam int NOTES_PER_LIST = 32;

  localparam int TICK_W   = 31;
  localparam int FIELD_W  = 4;
  localparam int SPAN_W   = 2 * TICK_W;
  localparam int CNT_W    = $clog2(NOTES_PER_LIST + 1);
  localparam int VOICE_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int STAFF_W  = $clog2(STAVES);
  localparam int LIST_DEPTH = NUM_VOICES * NOTES_PER_LIST;
  localparam int ADDR_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef struct packed {
    logic               new_measure;
    logic [TICK_W-1:0]  start_tick;
    logic [TICK_W-1:0]  end_tick;
    logic [FIELD_W-1:0] voice_index;
    logic [FIELD_W-1:0] staff_index;
  } in_beat_t;

  typedef struct packed {
    logic voice_overlap;
    logic dropped;
  } out_beat_t;

  // Query token passed from cell to cell along the staff chain.
  typedef struct packed {
    logic               valid;
    logic [STAFF_W-1:0] pos;
    logic [STAFF_W-1:0] staff;
    logic [VOICE_W-1:0] voice;
    logic [TICK_W-1:0]  start_tick;
    logic [TICK_W-1:0]  end_tick;
    logic               hit;
    logic               full;
  } tok_t;

  function automatic logic [ADDR_W-1:0] list_addr(input logic [VOICE_W-1:0] voice,
                                                  input logic [CNT_W-1:0] slot);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(voice) * ADDR_W'(NOTES_PER_LIST);
    return base + ADDR_W'(slot);
  endfunction

endpackage

@@ rtl/core/csio_cell.sv @@
// One staff cell: interval lists for every voice on one staff, scan and append.
module csio_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  csio_pkg::tok_t  tok_in,
  output csio_pkg::tok_t  tok_out
);
  import csio_pkg::*;

  logic [SPAN_W-1:0] mem [LIST_DEPTH];
  logic [CNT_W-1:0]  count [NUM_VOICES];

  logic              busy;
  logic              done;
  tok_t              tok;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  k;
  logic              rd_pend;
  logic [SPAN_W-1:0] rd_data;

  logic              is_target;
  logic              has_room;
  logic              write_en;
  logic              span_hit;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  assign is_target = (tok.pos == tok.staff);
  assign has_room  = (n < CNT_W'(NOTES_PER_LIST));
  assign write_en  = busy && is_target && has_room;
  assign rd_addr   = list_addr(tok.voice, k);
  assign wr_addr   = list_addr(tok.voice, n);
  assign span_hit  = (tok.start_tick < rd_data[TICK_W-1:0]) &&
                     (rd_data[SPAN_W-1:TICK_W] < tok.end_tick);

  always_comb begin
    tok_out       = tok;
    tok_out.valid = done;
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[wr_addr] <= {tok.start_tick, tok.end_tick};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      rd_pend <= 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (clear) begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          count[i] <= '0;
        end
      end
      if (!busy) begin
        if (tok_in.valid) begin
          tok     <= tok_in;
          n       <= count[tok_in.voice];
          k       <= '0;
          rd_pend <= 1'b0;
          busy    <= 1'b1;
        end
      end else if (is_target) begin
        // append to own list, or mark the list as full
        if (has_room) begin
          count[tok.voice] <= n + CNT_W'(1);
        end else begin
          tok.full <= 1'b1;
        end
        tok.pos <= tok.pos + STAFF_W'(1);
        busy    <= 1'b0;
        done    <= 1'b1;
      end else begin
        // scan stored intervals of this voice, one read per cycle
        if (k < n) begin
          k       <= k + CNT_W'(1);
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
        if (rd_pend && span_hit) begin
          tok.hit <= 1'b1;
        end
        if (k == n && !rd_pend) begin
          tok.pos <= tok.pos + STAFF_W'(1);
          busy    <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/cross_staff_interval_overlap_core.sv @@
// Top level: note intake, staff cell chain and per-voice sticky overlap marks.
//
//   channel | signals                          | carries
//   --------+----------------------------------+--------------------------------
//   input   | in_valid, in_ready, in_beat      | one note interval per beat
//   output  | out_valid, out_ready, out_beat   | overlap mark and drop flag
//
// One note at a time. A note with a bad voice or staff is dropped in S_CHECK. Otherwise
// the query token walks the STAVES staff cells, each other staff's cell reading its
// stored intervals one per cycle.
// Reset clears all counts and marks at once. The result holds while out_ready
// is low, and no new note is taken until the cycle after it is delivered.
module cross_staff_interval_overlap_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  csio_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output csio_pkg::out_beat_t out_beat
);
  import csio_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]            state;
  in_beat_t              req;
  out_beat_t             res;
  logic                  launch;
  logic [NUM_VOICES-1:0] marks;
  logic                  clear;
  logic                  accept;
  logic                  bad_voice;
  logic                  bad_staff;
  logic [VOICE_W-1:0]    vi;
  tok_t                  tok [STAVES+1];

  assign accept    = in_valid && in_ready;
  assign clear     = accept && in_beat.new_measure;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_beat  = res;

  assign bad_voice = ({1'b0, req.voice_index} >= (FIELD_W + 1)'(NUM_VOICES));
  assign bad_staff = ({1'b0, req.staff_index} >= (FIELD_W + 1)'(STAVES));
  assign vi        = req.voice_index[VOICE_W-1:0];

  always_comb begin
    tok[0].valid      = launch;
    tok[0].pos        = '0;
    tok[0].staff      = req.staff_index[STAFF_W-1:0];
    tok[0].voice      = vi;
    tok[0].start_tick = req.start_tick;
    tok[0].end_tick   = req.end_tick;
    tok[0].hit        = 1'b0;
    tok[0].full       = 1'b0;
  end

  for (genvar g = 0; g < STAVES; g++) begin : g_cell
    csio_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
      marks  <= '0;
    end else begin
      launch <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req <= in_beat;
            if (in_beat.new_measure) begin
              marks <= '0;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (bad_voice) begin
            res.voice_overlap <= 1'b0;
            res.dropped       <= 1'b1;
            state             <= S_OUT;
          end else if (bad_staff) begin
            res.voice_overlap <= marks[vi];
            res.dropped       <= 1'b1;
            state             <= S_OUT;
          end else begin
            launch <= 1'b1;
            state  <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok[STAVES].valid) begin
            if (tok[STAVES].full) begin
              res.voice_overlap <= marks[vi];
              res.dropped       <= 1'b1;
            end else begin
              if (tok[STAVES].hit) begin
                marks[vi] <= 1'b1;
              end
              res.voice_overlap <= marks[vi] | tok[STAVES].hit;
              res.dropped       <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the cross-staff interval overlap core.
module testbench;
  import csio_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int NOTE_TARGET  = 800;
  localparam int CALM_TAIL    = 100;
  localparam int PRINT_CAP    = 40;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [TICK_W-1:0] TICK_CHECKER = 31'h2AAA_AAAA;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } note_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  logic [TICK_W-1:0] held_start [NUM_VOICES][STAVES][NOTES_PER_LIST];
  logic [TICK_W-1:0] held_end   [NUM_VOICES][STAVES][NOTES_PER_LIST];
  int unsigned       held_count [NUM_VOICES][STAVES];
  bit                voice_mark [NUM_VOICES];

  out_beat_t   owed_results[$];
  note_row_t   directed_rows[$];
  out_beat_t   due;
  int unsigned error_count = 0;
  int unsigned notes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned staff_drops = 0;
  int unsigned full_drops = 0;
  int unsigned marked_results = 0;
  int unsigned quiet_cycles = 0;
  int          idle_pct = 30;
  int          stall_pct = 10;
  bit          calm = 1'b0;

  cross_staff_interval_overlap_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
  endtask

  function automatic out_beat_t judge_note(input in_beat_t b);
    out_beat_t   r;
    int unsigned v, st, n, o, k;
    bit          hit;
    r = '0;
    hit = 1'b0;
    if (b.new_measure) begin
      foreach (held_count[i, j]) held_count[i][j] = 0;
      foreach (voice_mark[i]) voice_mark[i] = 1'b0;
    end
    v = b.voice_index;
    st = b.staff_index;
    if (v >= NUM_VOICES) begin
      r.dropped = 1'b1;
      return r;
    end
    if (st >= STAVES) begin
      staff_drops++;
      r.voice_overlap = voice_mark[v];
      r.dropped = 1'b1;
      return r;
    end
    n = held_count[v][st];
    if (n >= NOTES_PER_LIST) begin
      full_drops++;
      r.voice_overlap = voice_mark[v];
      r.dropped = 1'b1;
      return r;
    end
    for (o = 0; o < STAVES; o++) begin
      if (o != st) begin
        for (k = 0; k < held_count[v][o]; k++) begin
          if (b.start_tick < held_end[v][o][k] && held_start[v][o][k] < b.end_tick) begin
            hit = 1'b1;
          end
        end
      end
    end
    if (hit) begin
      voice_mark[v] = 1'b1;
    end
    held_start[v][st][n] = b.start_tick;
    held_end[v][st][n] = b.end_tick;
    held_count[v][st] = n + 1;
    r.voice_overlap = voice_mark[v];
    return r;
  endfunction

  task automatic send_note(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t guess;
    int        gap;
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    guess = judge_note(b);
    owed_results.push_back(typed ? want : guess);
    notes_sent++;
    calm = (notes_sent >= NOTE_TARGET - CALM_TAIL);
    gap = (!calm && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_row(input bit nm, input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] e,
                         input int v, input int st, input bit typed,
                         input bit ov, input bit dr);
    note_row_t row;
    row.beat.new_measure = nm;
    row.beat.start_tick = s;
    row.beat.end_tick = e;
    row.beat.voice_index = FIELD_W'(v);
    row.beat.staff_index = FIELD_W'(st);
    row.typed = typed;
    row.want.voice_overlap = ov;
    row.want.dropped = dr;
    directed_rows.push_back(row);
  endtask

  task automatic play_random_measure();
    in_beat_t          b;
    int                mode, count, voice_pool, focus_voice, focus_staff, side_staff;
    logic [TICK_W-1:0] base;
    mode = $urandom_range(0, 9);
    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
    stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 25);
    base = $urandom_range(0, 1) ? TICK_W'($urandom_range(0, 32'h7FFF_0000)) : '0;
    focus_voice = $urandom_range(0, NUM_VOICES - 1);
    focus_staff = $urandom_range(0, STAVES - 1);
    side_staff = (focus_staff + $urandom_range(1, STAVES - 1)) % STAVES;
    voice_pool = $urandom_range(1, 4);
    if (mode <= 4) begin
      count = $urandom_range(4, 40);
    end else if (mode <= 6) begin
      count = $urandom_range(35, 75);
    end else if (mode == 7) begin
      count = $urandom_range(1, 8);
    end else begin
      count = $urandom_range(20, 60);
    end
    for (int i = 0; i < count && notes_sent < NOTE_TARGET; i++) begin
      b.new_measure = (i == 0);
      b.start_tick = base + TICK_W'($urandom_range(0, 1919));
      b.end_tick = b.start_tick + TICK_W'($urandom_range(0, 479));
      if ($urandom_range(0, 19) == 0) begin
        b.end_tick = base + TICK_W'($urandom_range(0, 1919));
      end
      b.voice_index = FIELD_W'((focus_voice + $urandom_range(0, voice_pool - 1)) % NUM_VOICES);
      b.staff_index = FIELD_W'($urandom_range(0, STAVES - 1));
      if (STAVES < 16 && $urandom_range(0, 19) == 0) begin
        b.staff_index = FIELD_W'($urandom_range(STAVES, 15));
      end
      case (mode)
        5, 6: begin
          b.voice_index = FIELD_W'(focus_voice);
          b.staff_index = FIELD_W'(($urandom_range(0, 3) == 0) ? side_staff : focus_staff);
        end
        7: begin
          b.new_measure = ($urandom_range(0, 7) == 0);
          b.start_tick = TICK_W'($urandom());
          b.end_tick = TICK_W'($urandom());
          b.voice_index = FIELD_W'($urandom_range(0, 15));
          b.staff_index = FIELD_W'($urandom_range(0, 15));
        end
        8, 9: begin
          b.voice_index = FIELD_W'($urandom_range(0, NUM_VOICES - 1));
          b.start_tick = base + TICK_W'($urandom_range(0, 199));
          b.end_tick = b.start_tick + TICK_W'($urandom_range(0, 60));
        end
        default: ;
      endcase
      send_note(b, 1'b0, '0);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && !calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (out_beat.voice_overlap === 1'b1) begin
        marked_results++;
      end
      if (owed_results.size() == 0) begin
        report_mismatch("result beat with no note pending");
      end else begin
        due = owed_results.pop_front();
        if (out_beat.voice_overlap !== due.voice_overlap) begin
          report_mismatch($sformatf("result %0d voice_overlap %b, want %b",
                                    results_seen, out_beat.voice_overlap, due.voice_overlap));
        end
        if (out_beat.dropped !== due.dropped) begin
          report_mismatch($sformatf("result %0d dropped %b, want %b",
                                    results_seen, out_beat.dropped, due.dropped));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    // voice 0: cross-staff overlap, touching spans
    add_row(1'b0, 31'd10, 31'd20, 0, 0, 1'b1, 1'b0, 1'b0);
    add_row(1'b0, 31'd15, 31'd25, 0, 1, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, 31'd20, 31'd30, 0, 2, 1'b0, 1'b0, 1'b0);
    // voice 1: tick extremes, reversed and empty spans
    add_row(1'b0, '0, TICK_MAX, 1, 0, 1'b1, 1'b0, 1'b0);
    add_row(1'b0, TICK_MAX, TICK_MAX, 1, 3, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, TICK_MAX, '0, 1, 1, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, 31'd5, 31'd5, 1, 2, 1'b0, 1'b0, 1'b0);
    // bad staff reports the current mark
    add_row(1'b0, 31'd0, 31'd9, 2, STAVES, 1'b1, 1'b0, 1'b1);
    add_row(1'b0, 31'd12, 31'd18, 0, 15, 1'b1, 1'b1, 1'b1);
    // measure clear on a dropped note, then fresh lists
    add_row(1'b1, 31'd12, 31'd18, 0, 7, 1'b1, 1'b0, 1'b1);
    add_row(1'b0, 31'd0, 31'd100, 0, 1, 1'b1, 1'b0, 1'b0);
    add_row(1'b0, 31'd100, 31'd200, 0, 0, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, 31'd99, 31'd100, 0, 3, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, 31'd50, 31'd60, 0, 1, 1'b0, 1'b0, 1'b0);
    // alternating bit patterns on the highest voice, then a measure clear
    add_row(1'b0, TICK_CHECKER, TICK_MAX ^ TICK_CHECKER, 15, 3, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, TICK_MAX ^ TICK_CHECKER, TICK_CHECKER, 15, 0, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, TICK_CHECKER, TICK_MAX, 15, 2, 1'b0, 1'b0, 1'b0);
    add_row(1'b1, 31'd300, 31'd400, 15, 0, 1'b1, 1'b0, 1'b0);
    add_row(1'b0, 31'd350, 31'd450, 15, 0, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, 31'd399, 31'd401, 15, 1, 1'b0, 1'b0, 1'b0);
    add_row(1'b0, 31'd0, 31'd1, 14, 1, 1'b1, 1'b0, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_note(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end
    while (notes_sent < NOTE_TARGET) begin
      play_random_measure();
    end
    in_valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d notes and %0d result beats: %0d bad-staff drops,",
             notes_sent, results_seen, staff_drops);
    $display("%0d full-list drops and %0d results with the voice overlap mark set.",
             full_drops, marked_results);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
